// ===== sv/button_short_long_press_detector_defines.svh =====
// Assertion macros shared by the button press detector RTL.
`ifndef BUTTON_SHORT_LONG_PRESS_DETECTOR_DEFINES_SVH
`define BUTTON_SHORT_LONG_PRESS_DETECTOR_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define BSLPD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a same-cycle implication outside reset.
`define BSLPD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication outside reset.
`define BSLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bslpd_pkg.sv =====
// Types and constants of the button short/long press detector.
package bslpd_pkg;

    localparam int CntW = 16;
    localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};

    // Reset values of the configuration registers
    localparam logic [CntW-1:0] RST_SAMPLE_INTERVAL = 16'd50;
    localparam logic [CntW-1:0] RST_SHORT_LIMIT     = 16'd1000;
    localparam logic [CntW-1:0] RST_LONG_LIMIT      = 16'd3000;
    localparam logic [CntW-1:0] RST_COOLDOWN        = 16'd500;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PRESSED = 2'd1,
        MODE_LONG    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        CFG_ENABLE          = 3'd0,
        CFG_SAMPLE_INTERVAL = 3'd1,
        CFG_SHORT_LIMIT     = 3'd2,
        CFG_LONG_LIMIT      = 3'd3,
        CFG_COOLDOWN        = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic            enable;
        logic [CntW-1:0] sample_interval_ms;
        logic [CntW-1:0] short_limit_ms;
        logic [CntW-1:0] long_limit_ms;
        logic [CntW-1:0] cooldown_ms;
    } cfg_t;

    typedef struct packed {
        event_t          press_event;
        mode_t           button_mode;
        logic            is_held;
        logic [CntW-1:0] held_duration_ms;
    } result_t;

endpackage

// ===== sv/bslpd_fsm.sv =====
// Press detector state machine: debounce, cooldown and hold counters.
`include "button_short_long_press_detector_defines.svh"

module bslpd_fsm
    import bslpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    pressed,
    input  cfg_t    cfg,
    output result_t res
);

    mode_t           mode_reg, mode_next;
    logic [CntW-1:0] cooldown_left_reg, cooldown_left_next;
    logic [CntW-1:0] since_sample_reg, since_sample_next;
    logic [CntW-1:0] held_ticks_reg, held_ticks_next;
    logic            long_fired_reg, long_fired_next;

    logic [CntW-1:0] since_inc;
    logic [CntW-1:0] held_inc;
    logic            past_cooldown;
    logic            go_idle;
    event_t          event_next;

    // Advance the state by one tick when a word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            cooldown_left_reg <= RST_COOLDOWN;
            since_sample_reg  <= CNT_MAX;
            held_ticks_reg    <= '0;
            long_fired_reg    <= 1'b0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            cooldown_left_reg <= cooldown_left_next;
            since_sample_reg  <= since_sample_next;
            held_ticks_reg    <= held_ticks_next;
            long_fired_reg    <= long_fired_next;
        end
    end

    // Compute next state and the tick's event
    always_comb
    begin
        since_inc = (since_sample_reg == CNT_MAX) ? CNT_MAX : since_sample_reg + 16'd1;
        held_inc  = (held_ticks_reg == CNT_MAX) ? CNT_MAX : held_ticks_reg + 16'd1;

        mode_next          = mode_reg;
        cooldown_left_next = cooldown_left_reg;
        since_sample_next  = since_sample_reg;
        held_ticks_next    = held_ticks_reg;
        long_fired_next    = long_fired_reg;
        event_next         = EV_NONE;
        past_cooldown      = 1'b1;
        go_idle            = 1'b0;

        if (cfg.enable)
        begin
            since_sample_next = since_inc;
            // Count down the cooldown; the tick stops while it is still running
            if (cooldown_left_reg != '0)
            begin
                cooldown_left_next = cooldown_left_reg - 16'd1;
                past_cooldown      = (cooldown_left_reg == 16'd1);
            end
            if (past_cooldown)
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    held_ticks_next = held_inc;
                end
                // Sample the pin once the debounce interval has passed
                if (since_inc >= cfg.sample_interval_ms)
                begin
                    since_sample_next = '0;
                    case (mode_reg)
                        MODE_IDLE:
                        begin
                            if (pressed)
                            begin
                                mode_next       = MODE_PRESSED;
                                held_ticks_next = '0;
                                long_fired_next = 1'b0;
                            end
                        end
                        MODE_PRESSED:
                        begin
                            if (!pressed)
                            begin
                                if (held_inc < cfg.short_limit_ms)
                                begin
                                    event_next = EV_SHORT;
                                end
                                go_idle = 1'b1;
                            end
                            else if (held_inc >= cfg.long_limit_ms && !long_fired_reg)
                            begin
                                mode_next       = MODE_LONG;
                                long_fired_next = 1'b1;
                                event_next      = EV_LONG;
                            end
                        end
                        MODE_LONG:
                        begin
                            if (!pressed)
                            begin
                                go_idle = 1'b1;
                            end
                        end
                        default:
                        begin
                            go_idle = 1'b1;
                        end
                    endcase
                end
            end
        end

        // Drop back to idle and re-arm the cooldown
        if (go_idle)
        begin
            mode_next          = MODE_IDLE;
            held_ticks_next    = '0;
            long_fired_next    = 1'b0;
            since_sample_next  = CNT_MAX;
            cooldown_left_next = cfg.cooldown_ms;
        end

        res.press_event      = event_next;
        res.button_mode      = mode_next;
        res.is_held          = (mode_next != MODE_IDLE);
        res.held_duration_ms = (mode_next != MODE_IDLE) ? held_ticks_next : '0;
    end

    `BSLPD_ASSERT_ALWAYS(a_long_flag_matches_mode,
        long_fired_reg == (mode_reg == MODE_LONG), "long flag out of step with mode")
    `BSLPD_ASSERT_IMPL(a_idle_no_hold, mode_reg == MODE_IDLE,
        held_ticks_reg == '0, "hold counter running while idle")
    `BSLPD_ASSERT_NEXT(a_disabled_holds_state, step && !cfg.enable,
        $stable(mode_reg) && $stable(held_ticks_reg) && $stable(cooldown_left_reg),
        "state moved while disabled")

endmodule

// ===== sv/button_short_long_press_detector.sv =====
// Top level of the debounced button short/long press detector.
//
// Usage: each input word is one millisecond tick carrying pin_level (active
// low, 0 = pressed) on in_valid/in_ready. Every tick yields exactly one
// result word on out_valid/out_ready: press_event, button_mode, is_held and
// held_duration_ms after that tick.
// Configuration: cfg_valid/cfg_index/cfg_data write one register per
// handshake (0 enable, 1 sample interval, 2 short limit, 3 long limit,
// 4 cooldown); cfg_ready is always high. Write only while no tick is in
// flight. Other indexes are ignored. Each result is registered and on the
// result port right after the edge that took its tick. Throughput is one
// tick per cycle unless the receiver stalls, set by the single result
// register; the state update is a single pass of counters and compares.
// Reset clears the result register, loads the register defaults (disabled,
// 50/1000/3000/500 ms) and puts the detector in idle with the cooldown armed.
// When the receiver stalls, the result holds and in_ready drops until the
// result is taken.
`include "button_short_long_press_detector_defines.svh"

module button_short_long_press_detector
    import bslpd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [CntW-1:0] cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            pin_level,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      press_event,
    output logic [1:0]      button_mode,
    output logic            is_held,
    output logic [CntW-1:0] held_duration_ms
);

    cfg_t    cfg_reg;
    result_t res_comb;
    result_t res_reg;
    logic    out_valid_reg;
    logic    step;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable             <= 1'b0;
            cfg_reg.sample_interval_ms <= RST_SAMPLE_INTERVAL;
            cfg_reg.short_limit_ms     <= RST_SHORT_LIMIT;
            cfg_reg.long_limit_ms      <= RST_LONG_LIMIT;
            cfg_reg.cooldown_ms        <= RST_COOLDOWN;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ENABLE:          cfg_reg.enable             <= cfg_data[0];
                CFG_SAMPLE_INTERVAL: cfg_reg.sample_interval_ms <= cfg_data;
                CFG_SHORT_LIMIT:     cfg_reg.short_limit_ms     <= cfg_data;
                CFG_LONG_LIMIT:      cfg_reg.long_limit_ms      <= cfg_data;
                CFG_COOLDOWN:        cfg_reg.cooldown_ms        <= cfg_data;
                default:             ;
            endcase
        end
    end

    bslpd_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .pressed (!pin_level),
        .cfg     (cfg_reg),
        .res     (res_comb)
    );

    // Track the result word's valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Capture the result word on each taken tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (step)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid        = out_valid_reg;
    assign press_event      = res_reg.press_event;
    assign button_mode      = res_reg.button_mode;
    assign is_held          = res_reg.is_held;
    assign held_duration_ms = res_reg.held_duration_ms;

    `BSLPD_ASSERT_IMPL(a_stall_blocks_input, out_valid_reg && !out_ready,
        !in_ready, "input taken while result stalled")
    `BSLPD_ASSERT_NEXT(a_tick_gives_result, step, out_valid_reg,
        "taken tick produced no result")
    `BSLPD_ASSERT_IMPL(a_held_matches_mode, out_valid_reg,
        is_held == (res_reg.button_mode != MODE_IDLE), "is_held disagrees with mode")
    `BSLPD_ASSERT_IMPL(a_long_event_mode, out_valid_reg && res_reg.press_event == EV_LONG,
        res_reg.button_mode == MODE_LONG, "long event outside long mode")

endmodule

// ===== bench/button_short_long_press_detector_tb.sv =====
// Self-checking bench for the debounced short/long button press detector.
module button_short_long_press_detector_tb;
    import bslpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic PIN_DOWN = 1'b0;
    localparam logic PIN_UP   = 1'b1;

    // Indexes past the last register; writes there must be dropped
    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    localparam result_t IDLE_RES = '{EV_NONE, MODE_IDLE, 1'b0, 16'd0};

    localparam int PHASES      = 4;
    localparam int PHASE_TICKS = 130;
    localparam int PHASE_GAP   [PHASES] = '{0, 84, 0, 28};
    localparam int PHASE_STALL [PHASES] = '{0, 0, 84, 28};

    typedef enum logic {ROW_WRITE, ROW_TICKS} row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        logic [2:0]      idx;
        logic [CntW-1:0] val;
        logic            pin;
        int unsigned     reps;
        logic            typed;
        result_t         want;
    } plan_row_t;

    localparam int PLAN_LEN = 46;

    // Directed walk: register writes and runs of identical ticks
    plan_row_t plan [PLAN_LEN] = '{
        // disabled out of reset: pin is ignored
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 1,     1'b1, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_UP,   1,     1'b1, IDLE_RES},
        '{ROW_WRITE, CFG_ENABLE,          16'd1,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_COOLDOWN,        16'd0,      PIN_UP,   0,     1'b0, IDLE_RES},
        // cooldown armed by reset swallows the press until it runs out
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 499,   1'b1, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 1,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_SAMPLE_INTERVAL, 16'd0,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_SHORT_LIMIT,     16'd6,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_LONG_LIMIT,      16'd12,     PIN_UP,   0,     1'b0, IDLE_RES},
        // short press, then long press with a silent release
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 3,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_UP,   1,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 14,    1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_UP,   1,     1'b0, IDLE_RES},
        // zero long limit fires on the first sample after the press
        '{ROW_WRITE, CFG_LONG_LIMIT,      16'd0,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 3,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_UP,   1,     1'b0, IDLE_RES},
        // zero short limit never reports a short press
        '{ROW_WRITE, CFG_SHORT_LIMIT,     16'd0,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_LONG_LIMIT,      16'd100,    PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 3,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_UP,   1,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_SPARE_LO,        16'hFFFF,   PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_SPARE_HI,        16'd0,      PIN_UP,   0,     1'b0, IDLE_RES},
        // widest sample interval: first sample at once, then none
        '{ROW_WRITE, CFG_SAMPLE_INTERVAL, 16'hFFFF,   PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 2,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_UP,   3,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_SAMPLE_INTERVAL, 16'd3,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_UP,   4,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_ENABLE,          16'd0,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 3,     1'b1, IDLE_RES},
        '{ROW_WRITE, CFG_ENABLE,          16'hFFFF,   PIN_UP,   0,     1'b0, IDLE_RES},
        // debounced press with a short cooldown
        '{ROW_WRITE, CFG_COOLDOWN,        16'd3,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_SAMPLE_INTERVAL, 16'd2,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_SHORT_LIMIT,     16'd20,     PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_LONG_LIMIT,      16'd40,     PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 5,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_UP,   3,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_UP,   6,     1'b0, IDLE_RES},
        // full-scale limits: a long hold still ends as a short press
        '{ROW_WRITE, CFG_SAMPLE_INTERVAL, 16'd0,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_SHORT_LIMIT,     16'hFFFF,   PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_LONG_LIMIT,      16'hFFFF,   PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_COOLDOWN,        16'd8,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 40,    1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_UP,   1,     1'b0, IDLE_RES},
        // cooldown drains, then a press right at its end
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_DOWN, 8,     1'b0, IDLE_RES},
        '{ROW_WRITE, CFG_COOLDOWN,        16'd0,      PIN_UP,   0,     1'b0, IDLE_RES},
        '{ROW_TICKS, CFG_ENABLE,          16'd0,      PIN_UP,   1,     1'b0, IDLE_RES}
    };

    logic            clk;
    logic            rst_n;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [2:0]      cfg_index;
    logic [CntW-1:0] cfg_data;
    logic            in_valid;
    logic            in_ready;
    logic            pin_level;
    logic            out_valid;
    logic            out_ready;
    logic [1:0]      press_event;
    logic [1:0]      button_mode;
    logic            is_held;
    logic [CntW-1:0] held_duration_ms;

    // Shadow registers and detector state
    cfg_t            cfg_shadow = '{1'b0, RST_SAMPLE_INTERVAL, RST_SHORT_LIMIT,
                                    RST_LONG_LIMIT, RST_COOLDOWN};
    mode_t           mode_now   = MODE_IDLE;
    logic [CntW-1:0] cool_left  = RST_COOLDOWN;
    logic [CntW-1:0] since_smp  = CNT_MAX;
    logic [CntW-1:0] hold_cnt   = '0;
    logic            long_seen  = 1'b0;

    result_t pending_results [$];
    result_t oldest;
    bit      failed     = 1'b0;
    int      gap_pct    = 0;
    int      stall_pct  = 0;
    int      live_ticks = 0;

    button_short_long_press_detector uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pin_level        (pin_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .press_event      (press_event),
        .button_mode      (button_mode),
        .is_held          (is_held),
        .held_duration_ms (held_duration_ms)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advance the detector by one tick and return the word it reports
    function automatic result_t advance_detector(logic pin);
        result_t res;
        event_t  ev;
        logic    pressed;
        logic    live;
        logic    to_idle;
        ev      = EV_NONE;
        pressed = ~pin;
        to_idle = 1'b0;
        if (cfg_shadow.enable)
        begin
            if (since_smp != CNT_MAX)
                since_smp = since_smp + 16'd1;
            live = 1'b1;
            if (cool_left != '0)
            begin
                cool_left = cool_left - 16'd1;
                live = (cool_left == '0);
            end
            if (live)
            begin
                if (mode_now != MODE_IDLE && hold_cnt != CNT_MAX)
                    hold_cnt = hold_cnt + 16'd1;
                if (since_smp >= cfg_shadow.sample_interval_ms)
                begin
                    since_smp = '0;
                    case (mode_now)
                        MODE_IDLE:
                        begin
                            if (pressed)
                            begin
                                mode_now  = MODE_PRESSED;
                                hold_cnt  = '0;
                                long_seen = 1'b0;
                            end
                        end
                        MODE_PRESSED:
                        begin
                            if (!pressed)
                            begin
                                if (hold_cnt < cfg_shadow.short_limit_ms)
                                    ev = EV_SHORT;
                                to_idle = 1'b1;
                            end
                            else if (hold_cnt >= cfg_shadow.long_limit_ms && !long_seen)
                            begin
                                mode_now  = MODE_LONG;
                                long_seen = 1'b1;
                                ev        = EV_LONG;
                            end
                        end
                        default:
                        begin
                            if (!pressed)
                                to_idle = 1'b1;
                        end
                    endcase
                    // Return to idle and re-arm the cooldown
                    if (to_idle)
                    begin
                        mode_now  = MODE_IDLE;
                        hold_cnt  = '0;
                        long_seen = 1'b0;
                        since_smp = CNT_MAX;
                        cool_left = cfg_shadow.cooldown_ms;
                    end
                end
            end
        end
        res.press_event      = ev;
        res.button_mode      = mode_now;
        res.is_held          = (mode_now != MODE_IDLE);
        res.held_duration_ms = (mode_now != MODE_IDLE) ? hold_cnt : '0;
        return res;
    endfunction

    // Pick a register value that keeps presses short enough to finish
    function automatic logic [CntW-1:0] pick_value(logic [2:0] idx);
        logic [CntW-1:0] v;
        case (cfg_idx_t'(idx))
            CFG_SAMPLE_INTERVAL: v = CntW'($urandom_range(0, 6));
            CFG_SHORT_LIMIT:
                v = ($urandom_range(0, 9) == 0) ? CntW'($urandom_range(0, 65535))
                                                : CntW'($urandom_range(0, 40));
            CFG_LONG_LIMIT:
                v = ($urandom_range(0, 9) == 0) ? CntW'($urandom_range(0, 65535))
                                                : CntW'($urandom_range(0, 80));
            CFG_COOLDOWN:        v = CntW'($urandom_range(0, 12));
            default:             v = CntW'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // Offer one tick word; called and returning at a falling edge
    task automatic send_tick(input logic pin, input logic typed = 1'b0,
                             input result_t typed_res = IDLE_RES);
        result_t res;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= pin;
        do
            @(posedge clk);
        while (!in_ready);
        if (cfg_shadow.enable)
            live_ticks++;
        res = advance_detector(pin);
        pending_results.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    // Hold the sender until every result word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // Write one register; called and returning at a falling edge
    task automatic write_reg(input logic [2:0] idx, input logic [CntW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (cfg_idx_t'(idx))
            CFG_ENABLE:          cfg_shadow.enable             = data[0];
            CFG_SAMPLE_INTERVAL: cfg_shadow.sample_interval_ms = data;
            CFG_SHORT_LIMIT:     cfg_shadow.short_limit_ms     = data;
            CFG_LONG_LIMIT:      cfg_shadow.long_limit_ms      = data;
            CFG_COOLDOWN:        cfg_shadow.cooldown_ms        = data;
            default:             ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stall the result port at random
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no prediction pending");
                failed = 1'b1;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (press_event !== oldest.press_event)
                begin
                    $error("press_event: expected %0d, actual %0d",
                           oldest.press_event, press_event);
                    failed = 1'b1;
                end
                if (button_mode !== oldest.button_mode)
                begin
                    $error("button_mode: expected %0d, actual %0d",
                           oldest.button_mode, button_mode);
                    failed = 1'b1;
                end
                if (is_held !== oldest.is_held)
                begin
                    $error("is_held: expected %0d, actual %0d", oldest.is_held, is_held);
                    failed = 1'b1;
                end
                if (held_duration_ms !== oldest.held_duration_ms)
                begin
                    $error("held_duration_ms: expected %0d, actual %0d",
                           oldest.held_duration_ms, held_duration_ms);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        plan_row_t       row;
        int              lim;
        int              hold;
        int              rel;
        logic [2:0]      idx;
        logic [CntW-1:0] rnd16;
        bit              burst;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pin_level = PIN_UP;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed plan
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            row = plan[i];
            if (row.kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(row.idx, row.val);
            end
            else
            begin
                repeat (row.reps) send_tick(row.pin, row.typed, row.want);
            end
        end

        // Random presses under each idling pattern
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_reg(CFG_ENABLE, 16'd1);
            for (int r = 1; r < 5; r++)
                write_reg(r[2:0], pick_value(r[2:0]));
            live_ticks = 0;
            while (live_ticks < PHASE_TICKS)
            begin
                burst     = ($urandom_range(0, 3) == 0);
                gap_pct   = burst ? 0 : PHASE_GAP[p];
                stall_pct = burst ? 0 : PHASE_STALL[p];
                if ($urandom_range(0, 9) < 8)
                begin
                    // Well-formed press with bounce at both edges
                    lim = (cfg_shadow.short_limit_ms > cfg_shadow.long_limit_ms)
                        ? int'(cfg_shadow.short_limit_ms) : int'(cfg_shadow.long_limit_ms);
                    lim  = (lim > 135) ? 150 : lim + 15;
                    hold = $urandom_range(1, lim);
                    rel  = $urandom_range(1, int'(cfg_shadow.sample_interval_ms)
                                           + int'(cfg_shadow.cooldown_ms) + 4);
                    repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
                    repeat (hold) send_tick(PIN_DOWN);
                    repeat ($urandom_range(0, 2)) send_tick(1'($urandom_range(0, 1)));
                    repeat (rel) send_tick(PIN_UP);
                end
                else
                begin
                    // Pure chatter on the pin
                    repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    drain_results();
                    if ($urandom_range(0, 3) == 0)
                    begin
                        // Short disabled stretch; state must survive it
                        rnd16 = CntW'($urandom);
                        write_reg(CFG_ENABLE, {rnd16[CntW-1:1], 1'b0});
                        repeat ($urandom_range(3, 10)) send_tick(1'($urandom_range(0, 1)));
                        drain_results();
                        rnd16 = CntW'($urandom);
                        write_reg(CFG_ENABLE, {rnd16[CntW-1:1], 1'b1});
                    end
                    else
                    begin
                        idx = 3'($urandom_range(1, 7));
                        write_reg(idx, pick_value(idx));
                    end
                end
            end
        end

        // Let the last words out, then report
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        if (!failed && pending_results.size() == 0)
            $display("button_short_long_press_detector_tb: PASS");
        else
            $display("button_short_long_press_detector_tb: FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(20_000_000);
        $display("button_short_long_press_detector_tb: FAIL");
        $finish;
    end

endmodule

// ===== button_short_long_press_detector.f =====
+incdir+sv
sv/bslpd_pkg.sv
sv/bslpd_fsm.sv
sv/button_short_long_press_detector.sv
bench/button_short_long_press_detector_tb.sv
